// File: rtl/core/ecpsm_pkg.sv
// ----------------------------------------------------------------------------
// ecpsm_pkg
// Shared types and constants of the curve point add and scalar multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpsm_pkg;

  localparam int PRIME_BITS_DEF  = 16;
  localparam int SCALAR_BITS_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_PRIME_RST   = 17;
  localparam int IN_DATA_W       = 88;
  localparam int OUT_DATA_W      = 40;

  localparam logic REG_FIELD_PRIME = 1'b0;
  localparam logic REG_CURVE_A     = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_RED,
    OP_RED_WR,
    OP_RES_INF,
    OP_ADD_BEGIN,
    OP_COPY_U,
    OP_COPY_V,
    OP_SET_INF,
    OP_MUL_SQ,
    OP_TAN1,
    OP_TAN2,
    OP_TAN3,
    OP_CHORD,
    OP_INV_INIT,
    OP_DIV_EU,
    OP_EU_Q,
    OP_MUL_QT,
    OP_EU_STEP,
    OP_INV_FIN,
    OP_MUL_NI,
    OP_LAM_WR,
    OP_MUL_LL,
    OP_X1,
    OP_X2,
    OP_X3,
    OP_MUL_LT,
    OP_ADD_WR,
    OP_SHIFT_K
  } op_t;

  typedef enum logic [1:0] {
    PAIR_FS,
    PAIR_RF,
    PAIR_FF
  } pair_t;

  typedef enum logic [2:0] {
    RED_A,
    RED_FX,
    RED_FY,
    RED_SX,
    RED_SY
  } red_t;

  typedef struct packed {
    op_t   op;
    pair_t pair;
    red_t  red;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic u_inf;
    logic v_inf;
    logic eq_x;
    logic y_sum_zero;
    logic r1_zero;
    logic k_lsb;
    logic p_small;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/ecpsm_mul.sv
// ----------------------------------------------------------------------------
// ecpsm_mul
// Bit-serial modular multiplier: shift-and-add with reduction each step.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpsm_mul
  import ecpsm_pkg::*;
#(
  parameter int PRIME_BITS = PRIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [PRIME_BITS-1:0] op_a,
  input  wire logic [PRIME_BITS-1:0] op_b,
  input  wire logic [PRIME_BITS-1:0] prime,
  output logic                       busy,
  output logic [PRIME_BITS-1:0]      prod
);

  localparam int W = PRIME_BITS;

  logic         busy_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] u_r;
  logic [W-1:0] v_r;

  function automatic logic [W-1:0] fadd(input logic [W-1:0] u, input logic [W-1:0] v,
                                        input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (v_r == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      u_r   <= op_a;
      v_r   <= op_b;
    end else if (busy_r && (v_r != '0)) begin
      if (v_r[0]) begin
        acc_r <= fadd(acc_r, u_r, prime);
      end
      u_r <= fadd(u_r, u_r, prime);
      v_r <= v_r >> 1;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

// File: rtl/core/ecpsm_div.sv
// ----------------------------------------------------------------------------
// ecpsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpsm_div
  import ecpsm_pkg::*;
#(
  parameter int PRIME_BITS = PRIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [PRIME_BITS-1:0] dividend,
  input  wire logic [PRIME_BITS-1:0] divisor,
  output logic                       busy,
  output logic [PRIME_BITS-1:0]      quot,
  output logic [PRIME_BITS-1:0]      rem
);

  localparam int W  = PRIME_BITS;
  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  quot_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  dvs_r;
  logic [W:0]    trial;

  assign trial = {rem_r, quot_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r  <= W'(trial - {1'b0, dvs_r});
        quot_r <= {quot_r[W-2:0], 1'b1};
      end else begin
        rem_r  <= trial[W-1:0];
        quot_r <= {quot_r[W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: rtl/core/ecpsm_dp.sv
// ----------------------------------------------------------------------------
// ecpsm_dp
// Field datapath: point registers, Euclid registers, multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpsm_dp
  import ecpsm_pkg::*;
#(
  parameter int PRIME_BITS  = PRIME_BITS_DEF,
  parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  input  wire logic [PRIME_BITS-1:0]  prime,
  input  wire logic [PRIME_BITS-1:0]  coef_a,
  input  wire logic [PRIME_BITS-1:0]  in_fx,
  input  wire logic [PRIME_BITS-1:0]  in_fy,
  input  wire logic                   in_finf,
  input  wire logic [PRIME_BITS-1:0]  in_sx,
  input  wire logic [PRIME_BITS-1:0]  in_sy,
  input  wire logic                   in_sinf,
  input  wire logic [SCALAR_BITS-1:0] in_k,
  output status_t                     status,
  output logic [PRIME_BITS-1:0]       res_x,
  output logic [PRIME_BITS-1:0]       res_y,
  output logic                        res_inf
);

  localparam int W = PRIME_BITS;

  logic [W-1:0] a_r, fx_r, fy_r, sx_r, sy_r, rx_r, ry_r;
  logic         finf_r, sinf_r, rinf_r;
  logic [W-1:0] ux_r, uy_r, vx_r, vy_r;
  logic         uinf_r, vinf_r;
  logic [W-1:0] num_r, lam_r, tx_r, r0_r, r1_r, t0_r, t1_r, q_r;
  logic [SCALAR_BITS-1:0] k_r;
  pair_t        pair_r;

  logic         mul_start, div_start, mul_busy, div_busy;
  logic [W-1:0] mul_a, mul_b, prod;
  logic [W-1:0] div_n, div_d, quot, rem;
  logic         wr_en, wr_inf;
  logic [W-1:0] wr_x, wr_y;

  function automatic logic [W-1:0] fadd(input logic [W-1:0] u, input logic [W-1:0] v,
                                        input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fsub(input logic [W-1:0] u, input logic [W-1:0] v,
                                        input logic [W-1:0] p);
    return (u >= v) ? (u - v) : (u + (p - v));
  endfunction

  always_comb begin
    mul_start = 1'b0;
    mul_a     = ux_r;
    mul_b     = ux_r;
    div_start = 1'b0;
    div_n     = r0_r;
    div_d     = r1_r;
    case (cmd.op)
      OP_MUL_SQ: begin
        mul_start = 1'b1;
      end
      OP_MUL_QT: begin
        mul_start = 1'b1;
        mul_a     = q_r;
        mul_b     = t1_r;
      end
      OP_MUL_NI: begin
        mul_start = 1'b1;
        mul_a     = num_r;
        mul_b     = t0_r;
      end
      OP_MUL_LL: begin
        mul_start = 1'b1;
        mul_a     = lam_r;
        mul_b     = lam_r;
      end
      OP_MUL_LT: begin
        mul_start = 1'b1;
        mul_a     = lam_r;
        mul_b     = num_r;
      end
      OP_DIV_EU: begin
        div_start = 1'b1;
      end
      OP_DIV_RED: begin
        div_start = 1'b1;
        div_d     = prime;
        case (cmd.red)
          RED_A:   div_n = a_r;
          RED_FX:  div_n = fx_r;
          RED_FY:  div_n = fy_r;
          RED_SX:  div_n = sx_r;
          RED_SY:  div_n = sy_r;
          default: div_n = a_r;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_x   = tx_r;
    wr_y   = fsub(prod, uy_r, prime);
    wr_inf = 1'b0;
    case (cmd.op)
      OP_ADD_WR: begin
        wr_en = 1'b1;
      end
      OP_COPY_U: begin
        wr_en  = 1'b1;
        wr_x   = ux_r;
        wr_y   = uy_r;
        wr_inf = uinf_r;
      end
      OP_COPY_V: begin
        wr_en  = 1'b1;
        wr_x   = vx_r;
        wr_y   = vy_r;
        wr_inf = vinf_r;
      end
      OP_SET_INF: begin
        wr_en  = 1'b1;
        wr_x   = '0;
        wr_y   = '0;
        wr_inf = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a_r    <= coef_a;
        fx_r   <= in_fx;
        fy_r   <= in_fy;
        finf_r <= in_finf;
        sx_r   <= in_sx;
        sy_r   <= in_sy;
        sinf_r <= in_sinf;
        k_r    <= in_k;
      end
      OP_RED_WR: begin
        case (cmd.red)
          RED_A:   a_r  <= rem;
          RED_FX:  fx_r <= rem;
          RED_FY:  fy_r <= rem;
          RED_SX:  sx_r <= rem;
          RED_SY:  sy_r <= rem;
          default: a_r  <= rem;
        endcase
      end
      OP_RES_INF: begin
        rx_r   <= '0;
        ry_r   <= '0;
        rinf_r <= 1'b1;
      end
      OP_ADD_BEGIN: begin
        pair_r <= cmd.pair;
        case (cmd.pair)
          PAIR_RF: begin
            ux_r <= rx_r; uy_r <= ry_r; uinf_r <= rinf_r;
            vx_r <= fx_r; vy_r <= fy_r; vinf_r <= finf_r;
          end
          PAIR_FF: begin
            ux_r <= fx_r; uy_r <= fy_r; uinf_r <= finf_r;
            vx_r <= fx_r; vy_r <= fy_r; vinf_r <= finf_r;
          end
          default: begin
            ux_r <= fx_r; uy_r <= fy_r; uinf_r <= finf_r;
            vx_r <= sx_r; vy_r <= sy_r; vinf_r <= sinf_r;
          end
        endcase
      end
      OP_TAN1: begin
        num_r <= fadd(prod, prod, prime);
        r1_r  <= fadd(uy_r, uy_r, prime);
      end
      OP_TAN2: num_r <= fadd(num_r, prod, prime);
      OP_TAN3: num_r <= fadd(num_r, a_r, prime);
      OP_CHORD: begin
        num_r <= fsub(vy_r, uy_r, prime);
        r1_r  <= fsub(vx_r, ux_r, prime);
      end
      OP_INV_INIT: begin
        r0_r <= prime;
        t0_r <= '0;
        t1_r <= W'(1);
      end
      OP_EU_Q: q_r <= (quot >= prime) ? (quot - prime) : quot;
      OP_EU_STEP: begin
        t1_r <= fsub(t0_r, prod, prime);
        t0_r <= t1_r;
        r0_r <= r1_r;
        r1_r <= rem;
      end
      OP_INV_FIN: t0_r <= (r0_r == W'(1)) ? t0_r : '0;
      OP_LAM_WR:  lam_r <= prod;
      OP_X1:      tx_r <= fsub(prod, ux_r, prime);
      OP_X2:      tx_r <= fsub(tx_r, vx_r, prime);
      OP_X3:      num_r <= fsub(ux_r, tx_r, prime);
      OP_SHIFT_K: k_r <= k_r >> 1;
      default: begin
      end
    endcase
    if (wr_en) begin
      if (pair_r == PAIR_FF) begin
        fx_r   <= wr_x;
        fy_r   <= wr_y;
        finf_r <= wr_inf;
      end else begin
        rx_r   <= wr_x;
        ry_r   <= wr_y;
        rinf_r <= wr_inf;
      end
    end
  end

  ecpsm_mul #(.PRIME_BITS(PRIME_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prime (prime),
    .busy  (mul_busy),
    .prod  (prod)
  );

  ecpsm_div #(.PRIME_BITS(PRIME_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    status.busy       = mul_busy | div_busy;
    status.u_inf      = uinf_r;
    status.v_inf      = vinf_r;
    status.eq_x       = (ux_r == vx_r);
    status.y_sum_zero = (fadd(uy_r, vy_r, prime) == '0);
    status.r1_zero    = (r1_r == '0);
    status.k_lsb      = k_r[0];
    status.p_small    = (prime < W'(2));
  end

  assign res_x   = rx_r;
  assign res_y   = ry_r;
  assign res_inf = rinf_r;

endmodule

`default_nettype wire

// File: rtl/core/ecpsm_ctrl.sv
// ----------------------------------------------------------------------------
// ecpsm_ctrl
// Sequencer: reductions, double-and-add loop and point addition steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpsm_ctrl
  import ecpsm_pkg::*;
#(
  parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire logic    in_mode,
  input  wire status_t status,
  input  wire logic    out_full,
  output logic         in_tready,
  output logic         out_load,
  output cmd_t         cmd
);

  localparam int CW = (SCALAR_BITS > 1) ? $clog2(SCALAR_BITS) : 1;

  typedef enum logic [28:0] {
    S_IDLE      = 29'd1 << 0,
    S_RED_GO    = 29'd1 << 1,
    S_RED_WR    = 29'd1 << 2,
    S_WAIT      = 29'd1 << 3,
    S_START     = 29'd1 << 4,
    S_BIT       = 29'd1 << 5,
    S_ADD_BEGIN = 29'd1 << 6,
    S_ADD_CHK   = 29'd1 << 7,
    S_TAN_MUL   = 29'd1 << 8,
    S_TAN1      = 29'd1 << 9,
    S_TAN2      = 29'd1 << 10,
    S_TAN3      = 29'd1 << 11,
    S_INV_INIT  = 29'd1 << 12,
    S_EU_CHK    = 29'd1 << 13,
    S_EU_Q      = 29'd1 << 14,
    S_EU_MUL    = 29'd1 << 15,
    S_EU_STEP   = 29'd1 << 16,
    S_INV_FIN   = 29'd1 << 17,
    S_LAM_MUL   = 29'd1 << 18,
    S_LAM_WR    = 29'd1 << 19,
    S_SQ_MUL    = 29'd1 << 20,
    S_X1        = 29'd1 << 21,
    S_X2        = 29'd1 << 22,
    S_X3        = 29'd1 << 23,
    S_Y_MUL     = 29'd1 << 24,
    S_Y2        = 29'd1 << 25,
    S_ADD_END   = 29'd1 << 26,
    S_FIN_INF   = 29'd1 << 27,
    S_DONE      = 29'd1 << 28
  } state_t;

  state_t        state_r, state_nxt;
  state_t        ret_r, ret_nxt;
  pair_t         pair_r, pair_nxt;
  red_t          red_r, red_nxt;
  logic          mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pair_nxt  = pair_r;
    red_nxt   = red_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    cmd       = '{op: OP_NONE, pair: pair_r, red: red_r};
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          mode_nxt  = in_mode;
          red_nxt   = RED_A;
          state_nxt = status.p_small ? S_FIN_INF : S_RED_GO;
        end
      end
      S_RED_GO: begin
        cmd.op    = OP_DIV_RED;
        ret_nxt   = S_RED_WR;
        state_nxt = S_WAIT;
      end
      S_RED_WR: begin
        cmd.op = OP_RED_WR;
        if (red_r == RED_SY) begin
          state_nxt = S_START;
        end else begin
          red_nxt   = red_t'(red_r + 3'd1);
          state_nxt = S_RED_GO;
        end
      end
      S_WAIT: begin
        if (!status.busy) begin
          state_nxt = ret_r;
        end
      end
      S_START: begin
        cmd.op  = OP_RES_INF;
        cnt_nxt = '0;
        if (!mode_r) begin
          pair_nxt  = PAIR_FS;
          state_nxt = S_ADD_BEGIN;
        end else begin
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        pair_nxt  = status.k_lsb ? PAIR_RF : PAIR_FF;
        state_nxt = S_ADD_BEGIN;
      end
      S_ADD_BEGIN: begin
        cmd.op    = OP_ADD_BEGIN;
        state_nxt = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (status.u_inf) begin
          cmd.op    = OP_COPY_V;
          state_nxt = S_ADD_END;
        end else if (status.v_inf) begin
          cmd.op    = OP_COPY_U;
          state_nxt = S_ADD_END;
        end else if (status.eq_x && status.y_sum_zero) begin
          cmd.op    = OP_SET_INF;
          state_nxt = S_ADD_END;
        end else if (status.eq_x) begin
          state_nxt = S_TAN_MUL;
        end else begin
          cmd.op    = OP_CHORD;
          state_nxt = S_INV_INIT;
        end
      end
      S_TAN_MUL: begin
        cmd.op    = OP_MUL_SQ;
        ret_nxt   = S_TAN1;
        state_nxt = S_WAIT;
      end
      S_TAN1: begin
        cmd.op    = OP_TAN1;
        state_nxt = S_TAN2;
      end
      S_TAN2: begin
        cmd.op    = OP_TAN2;
        state_nxt = S_TAN3;
      end
      S_TAN3: begin
        cmd.op    = OP_TAN3;
        state_nxt = S_INV_INIT;
      end
      S_INV_INIT: begin
        cmd.op    = OP_INV_INIT;
        state_nxt = S_EU_CHK;
      end
      S_EU_CHK: begin
        if (status.r1_zero) begin
          state_nxt = S_INV_FIN;
        end else begin
          cmd.op    = OP_DIV_EU;
          ret_nxt   = S_EU_Q;
          state_nxt = S_WAIT;
        end
      end
      S_EU_Q: begin
        cmd.op    = OP_EU_Q;
        state_nxt = S_EU_MUL;
      end
      S_EU_MUL: begin
        cmd.op    = OP_MUL_QT;
        ret_nxt   = S_EU_STEP;
        state_nxt = S_WAIT;
      end
      S_EU_STEP: begin
        cmd.op    = OP_EU_STEP;
        state_nxt = S_EU_CHK;
      end
      S_INV_FIN: begin
        cmd.op    = OP_INV_FIN;
        state_nxt = S_LAM_MUL;
      end
      S_LAM_MUL: begin
        cmd.op    = OP_MUL_NI;
        ret_nxt   = S_LAM_WR;
        state_nxt = S_WAIT;
      end
      S_LAM_WR: begin
        cmd.op    = OP_LAM_WR;
        state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.op    = OP_MUL_LL;
        ret_nxt   = S_X1;
        state_nxt = S_WAIT;
      end
      S_X1: begin
        cmd.op    = OP_X1;
        state_nxt = S_X2;
      end
      S_X2: begin
        cmd.op    = OP_X2;
        state_nxt = S_X3;
      end
      S_X3: begin
        cmd.op    = OP_X3;
        state_nxt = S_Y_MUL;
      end
      S_Y_MUL: begin
        cmd.op    = OP_MUL_LT;
        ret_nxt   = S_Y2;
        state_nxt = S_WAIT;
      end
      S_Y2: begin
        cmd.op    = OP_ADD_WR;
        state_nxt = S_ADD_END;
      end
      S_ADD_END: begin
        case (pair_r)
          PAIR_RF: begin
            pair_nxt  = PAIR_FF;
            state_nxt = S_ADD_BEGIN;
          end
          PAIR_FF: begin
            cmd.op = OP_SHIFT_K;
            if (cnt_r == CW'(SCALAR_BITS - 1)) begin
              state_nxt = S_DONE;
            end else begin
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_BIT;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FIN_INF: begin
        cmd.op    = OP_RES_INF;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_full) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      pair_r  <= PAIR_FS;
      red_r   <= RED_A;
      mode_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pair_r  <= pair_nxt;
      red_r   <= red_nxt;
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MUL_SQ || cmd.op == OP_MUL_QT || cmd.op == OP_MUL_NI ||
     cmd.op == OP_MUL_LL || cmd.op == OP_MUL_LT || cmd.op == OP_DIV_EU ||
     cmd.op == OP_DIV_RED) |-> !status.busy)
    else $error("arithmetic unit started while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_full)
    else $error("result loaded over an untaken result");

  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after a transfer");

  a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) != S_WAIT && state_r == S_WAIT) |-> status.busy)
    else $error("wait entered without a running unit");

endmodule

`default_nettype wire

// File: rtl/core/ec_point_add_and_scalar_multiply.sv
// ----------------------------------------------------------------------------
// ec_point_add_and_scalar_multiply
// Affine point addition and double-and-add scalar multiply over GF(p).
// ----------------------------------------------------------------------------
// One item is in work at a time; the next is taken while a result still waits.
// An addition (tuser = 0) costs five reductions, then one point operation: an
// extended Euclid inverse of up to about 1.44*PRIME_BITS rounds, each a division
// and a multiply, and three more multiplies (four for a doubling). A multiply
// (tuser = 1) runs up to 2*SCALAR_BITS point operations.
// The bit-serial divider and multiplier are shared by the reductions and the point
// operations.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_point_add_and_scalar_multiply
  import ecpsm_pkg::*;
#(
  parameter int PRIME_BITS  = PRIME_BITS_DEF,
  parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // first_x, first_y, first_at_infinity, second_x, second_y,
  // second_at_infinity, scalar
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  wire logic                  in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // result_x, result_y, result_at_infinity
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int W = PRIME_BITS;

  logic [W-1:0] prime_r, coef_a_r;
  logic [63:0]  wdata64, rdata64;
  logic         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wdata64    = 64'(cfg_pwdata);
  assign rdata64    = (cfg_paddr[2] == REG_CURVE_A) ? 64'(coef_a_r) : 64'(prime_r);
  assign cfg_prdata = rdata64[CFG_DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r  <= W'(CFG_PRIME_RST);
      coef_a_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_CURVE_A) begin
        coef_a_r <= wdata64[W-1:0];
      end else begin
        prime_r <= wdata64[W-1:0];
      end
    end
  end

  logic [63:0] fx64, fy64, sx64, sy64, k64;
  assign fx64 = 64'(in_tdata[15:0]);
  assign fy64 = 64'(in_tdata[31:16]);
  assign sx64 = 64'(in_tdata[48:33]);
  assign sy64 = 64'(in_tdata[64:49]);
  assign k64  = 64'(in_tdata[81:66]);

  cmd_t         cmd;
  status_t      status;
  logic         out_load, out_full;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] res_x, res_y;
  logic         res_inf;
  logic [63:0]  ox64, oy64;
  logic [FIELD_W-1:0] out_x_r, out_y_r;
  logic         out_inf_r;

  assign out_full = out_valid_r & ~out_tready;

  ecpsm_ctrl #(.SCALAR_BITS(SCALAR_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .status    (status),
    .out_full  (out_full),
    .in_tready (in_tready),
    .out_load  (out_load),
    .cmd       (cmd)
  );

  ecpsm_dp #(.PRIME_BITS(PRIME_BITS), .SCALAR_BITS(SCALAR_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .prime   (prime_r),
    .coef_a  (coef_a_r),
    .in_fx   (fx64[W-1:0]),
    .in_fy   (fy64[W-1:0]),
    .in_finf (in_tdata[32]),
    .in_sx   (sx64[W-1:0]),
    .in_sy   (sy64[W-1:0]),
    .in_sinf (in_tdata[65]),
    .in_k    (k64[SCALAR_BITS-1:0]),
    .status  (status),
    .res_x   (res_x),
    .res_y   (res_y),
    .res_inf (res_inf)
  );

  assign ox64 = res_inf ? 64'd0 : 64'(res_x);
  assign oy64 = res_inf ? 64'd0 : 64'(res_y);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r   <= ox64[FIELD_W-1:0];
      out_y_r   <= oy64[FIELD_W-1:0];
      out_inf_r <= res_inf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_inf_r, out_y_r, out_x_r};

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives point additions and scalar multiplies through the stream port under
// several curve settings and idling phases, predicts each result point with a
// local affine arithmetic model and compares every field of every transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import ecpsm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        inf;
  } point_t;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 30000;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  longint unsigned prime_q;
  longint unsigned coef_a;
  point_t          expected_points[$];
  int              send_idle_pct;
  int              recv_stall_pct;
  int              error_count;
  int              quiet_cycles;

  ec_point_add_and_scalar_multiply DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned fadd(longint unsigned u, longint unsigned v,
                                           longint unsigned p);
    return (u + v) % p;
  endfunction

  function automatic longint unsigned fsub(longint unsigned u, longint unsigned v,
                                           longint unsigned p);
    return (u >= v) ? (u - v) : (u + p - v);
  endfunction

  function automatic longint unsigned fmul(longint unsigned u, longint unsigned v,
                                           longint unsigned p);
    return ((u % p) * (v % p)) % p;
  endfunction

  function automatic longint unsigned finv(longint unsigned v, longint unsigned p);
    longint unsigned r0, r1, t0, t1, q, r2, t2;
    r0 = p;
    r1 = v % p;
    t0 = 0;
    t1 = 1 % p;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = fsub(t0, fmul(q % p, t1, p), p);
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    return (r0 == 1) ? t0 : 0;
  endfunction

  function automatic point_t curve_add(point_t s, point_t t, longint unsigned p,
                                       longint unsigned a);
    point_t          r;
    longint unsigned slope, num, den, rx;
    if (s.inf) return t;
    if (t.inf) return s;
    r = '{16'd0, 16'd0, 1'b1};
    if (s.x == t.x) begin
      if (fadd(s.y, t.y, p) == 0) return r;
      num = fadd(fmul(3, fmul(s.x, s.x, p), p), a, p);
      den = fmul(2, s.y, p);
    end else begin
      num = fsub(t.y, s.y, p);
      den = fsub(t.x, s.x, p);
    end
    slope = fmul(num, finv(den, p), p);
    rx = fsub(fsub(fmul(slope, slope, p), s.x, p), t.x, p);
    r.x = rx[15:0];
    r.y = 16'(fsub(fmul(slope, fsub(s.x, rx, p), p), s.y, p));
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic point_t predict_point(logic mode, point_t a_pt, point_t b_pt,
                                           logic [15:0] k);
    point_t res, f, s;
    res = '{16'd0, 16'd0, 1'b1};
    if (prime_q >= 2) begin
      f = '{16'(a_pt.x % prime_q), 16'(a_pt.y % prime_q), a_pt.inf};
      if (!mode) begin
        s = '{16'(b_pt.x % prime_q), 16'(b_pt.y % prime_q), b_pt.inf};
        res = curve_add(f, s, prime_q, coef_a % prime_q);
      end else begin
        for (int i = 0; i < 16; i++) begin
          if (k[i]) res = curve_add(res, f, prime_q, coef_a % prime_q);
          f = curve_add(f, f, prime_q, coef_a % prime_q);
        end
      end
      if (res.inf) begin
        res.x = 16'd0;
        res.y = 16'd0;
      end
    end
    return res;
  endfunction

  task automatic write_register(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_FIELD_PRIME) prime_q = value;
    else coef_a = value;
  endtask

  task automatic send_item(logic mode, point_t a_pt, point_t b_pt, logic [15:0] k);
    do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    in_tdata  <= IN_DATA_W'({k, b_pt.inf, b_pt.y, b_pt.x, a_pt.inf, a_pt.y, a_pt.x});
    in_tuser  <= mode;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_points.push_back(predict_point(mode, a_pt, b_pt, k));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_curve(logic [15:0] p, logic [15:0] a);
    wait_drained();
    write_register(REG_FIELD_PRIME, p);
    write_register(REG_CURVE_A, a);
  endtask

  function automatic point_t rand_point(int bias);
    point_t pt;
    if ($urandom_range(99) < bias) begin
      pt.x = 16'($urandom_range(int'(prime_q) - 1));
      pt.y = 16'($urandom_range(int'(prime_q) - 1));
    end else begin
      pt.x = 16'($urandom);
      pt.y = 16'($urandom);
    end
    pt.inf = ($urandom_range(9) == 0);
    return pt;
  endfunction

  function automatic logic [15:0] rand_scalar();
    case ($urandom_range(3))
      0: return 16'($urandom_range(15));
      1: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    point_t g, z, h, e;
    g = '{16'd5, 16'd1, 1'b0};
    z = '{16'd0, 16'd0, 1'b1};
    h = '{16'd6, 16'd3, 1'b0};
    e = '{16'hFFFF, 16'hFFFF, 1'b0};
    set_curve(16'd17, 16'd2);
    send_item(1'b0, g, h, 16'd0);
    send_item(1'b0, g, g, 16'hFFFF);
    send_item(1'b0, g, '{16'd5, 16'd16, 1'b0}, 16'd0);
    send_item(1'b0, z, g, 16'd0);
    send_item(1'b0, g, z, 16'd0);
    send_item(1'b0, z, z, 16'd0);
    send_item(1'b0, e, '{16'd22, 16'd18, 1'b0}, 16'd0);
    send_item(1'b0, '{16'd0, 16'd0, 1'b0}, e, 16'd0);
    send_item(1'b1, g, e, 16'd0);
    send_item(1'b1, g, h, 16'd1);
    send_item(1'b1, g, h, 16'd19);
    send_item(1'b1, z, h, 16'd7);
    send_item(1'b1, e, z, 16'hFFFF);
    send_item(1'b1, '{16'd3, 16'd0, 1'b0}, z, 16'd2);
    set_curve(16'd15, 16'd4);
    send_item(1'b0, '{16'd1, 16'd3, 1'b0}, '{16'd4, 16'd6, 1'b0}, 16'd0);
    send_item(1'b1, '{16'd2, 16'd5, 1'b0}, z, 16'd9);
    set_curve(16'd1, 16'd0);
    send_item(1'b0, g, h, 16'd0);
    send_item(1'b1, g, h, 16'd3);
    set_curve(16'd0, 16'hFFFF);
    send_item(1'b0, g, h, 16'd0);
    set_curve(16'd65521, 16'hFFFF);
    send_item(1'b0, e, '{16'd12345, 16'd54321, 1'b0}, 16'd0);
    send_item(1'b1, '{16'd100, 16'd200, 1'b0}, z, 16'hFFFF);
  endtask

  task automatic test_random(logic [15:0] p, logic [15:0] a, int count, int idle,
                             int stall);
    set_curve(p, a);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      point_t f, s;
      f = rand_point(85);
      s = ($urandom_range(4) == 0) ? f : rand_point(85);
      if ($urandom_range(5) == 0) s.y = 16'(fsub(0, f.y % prime_q, prime_q));
      send_item(1'($urandom_range(1)), f, s, rand_scalar());
    end
  endtask

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result transfer %h", out_tdata);
        error_count++;
      end else begin
        point_t ex;
        ex = expected_points.pop_front();
        if (out_tdata[15:0] !== ex.x) begin
          $error("result_x expected %h actual %h", ex.x, out_tdata[15:0]);
          error_count++;
        end
        if (out_tdata[31:16] !== ex.y) begin
          $error("result_y expected %h actual %h", ex.y, out_tdata[31:16]);
          error_count++;
        end
        if (out_tdata[32] !== ex.inf) begin
          $error("result_at_infinity expected %b actual %b", ex.inf, out_tdata[32]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL ec_point_add_and_scalar_multiply");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tvalid = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    prime_q = CFG_PRIME_RST;
    coef_a = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    quiet_cycles = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(16'd97, 16'd2, 75, 0, 0);
    test_random(16'd65521, 16'd7, 75, 52, 0);
    test_random(16'd257, 16'd65535, 75, 0, 52);
    test_random(16'd5, 16'd0, 75, 34, 34);
    wait_drained();
    if (error_count == 0)
      $display("PASS ec_point_add_and_scalar_multiply");
    else
      $display("FAIL ec_point_add_and_scalar_multiply");
    $finish;
  end

endmodule

`default_nettype wire
